### hdl/bal_pkg.sv
// ----------------------------------------------------------------------------
// Buddy allocator package
// Shared widths, node state codes, result codes, datapath command codes and command/status types.
// ----------------------------------------------------------------------------
package bal_pkg;

  localparam int MEM_UNITS = 64;
  localparam int LOG_UNITS = $clog2(MEM_UNITS);
  localparam int AW        = LOG_UNITS;          // unit address width
  localparam int NW        = LOG_UNITS + 1;      // node index width
  localparam int SW        = LOG_UNITS + 1;      // size / base width
  localparam int LW        = $clog2(LOG_UNITS + 1);
  localparam int CW        = 7;                  // request count port width
  localparam int TREE_DEPTH = 2 * MEM_UNITS;

  localparam logic [1:0] ST_ABSENT = 2'd0;
  localparam logic [1:0] ST_FREE   = 2'd1;
  localparam logic [1:0] ST_SPLIT  = 2'd2;
  localparam logic [1:0] ST_USED   = 2'd3;

  localparam logic [1:0] RES_OK      = 2'd0;
  localparam logic [1:0] RES_BAD_CNT = 2'd1;
  localparam logic [1:0] RES_NO_SPC  = 2'd2;
  localparam logic [1:0] RES_NO_BLK  = 2'd3;

  localparam logic [3:0] OP_NONE    = 4'd0;
  localparam logic [3:0] OP_LOAD    = 4'd1;
  localparam logic [3:0] OP_RD      = 4'd2;
  localparam logic [3:0] OP_RDB     = 4'd3;
  localparam logic [3:0] OP_ASTEP   = 4'd4;
  localparam logic [3:0] OP_AFOUND  = 4'd5;
  localparam logic [3:0] OP_WR_HI   = 4'd6;
  localparam logic [3:0] OP_SPLIT   = 4'd7;
  localparam logic [3:0] OP_WR_USED = 4'd8;
  localparam logic [3:0] OP_FDESC   = 4'd9;
  localparam logic [3:0] OP_FFOUND  = 4'd10;
  localparam logic [3:0] OP_WR_ABSN = 4'd11;
  localparam logic [3:0] OP_WR_ABSB = 4'd12;
  localparam logic [3:0] OP_WR_FREE = 4'd13;
  localparam logic [3:0] OP_ERR     = 4'd14;

  typedef struct packed {
    logic [3:0] op;
    logic [1:0] err;
  } dp_cmd_t;

  typedef struct packed {
    logic       is_free_req;
    logic       cnt_bad;
    logic [1:0] rd_st;
    logic       at_root;
    logic       match;
    logic       can_desc;
    logic       split_more;
  } dp_stat_t;

  // ceil(log2(count)) for a nonzero count
  function automatic int cnt_level(input logic [CW-1:0] cnt);
    int k;
    k = 0;
    for (int i = 0; i < CW; i++) begin
      if ((32'd1 << i) < 32'(cnt)) k = i + 1;
    end
    return k;
  endfunction

endpackage

### hdl/bal_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bal_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    rdata <= mem_r[raddr];
  end

endmodule

### hdl/bal_datapath.sv
// ----------------------------------------------------------------------------
// Buddy allocator datapath
// Node state memory with valid bits, tree walk registers and result register.
// ----------------------------------------------------------------------------
module bal_datapath import bal_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  dp_cmd_t       cmd,
  input  logic          in_req_type,
  input  logic [CW-1:0] in_block_count,
  input  logic [AW-1:0] in_start_address,
  output dp_stat_t      stat,
  output logic [1:0]    res_status,
  output logic [AW-1:0] res_address,
  output logic [SW-1:0] res_size
);

  logic [NW-1:0] n_r, first_r;
  logic [LW-1:0] lvl_r, want_r;
  logic [SW-1:0] base_r;
  logic [AW-1:0] addr_r;
  logic [CW-1:0] cnt_r;
  logic          type_r;
  logic [1:0]    res_status_r;
  logic [AW-1:0] res_address_r;
  logic [SW-1:0] res_size_r;

  logic [TREE_DEPTH-1:0] vld_r;
  logic                  vld_q_r;
  logic [NW-1:0]         raddr_q_r;

  logic          we;
  logic [NW-1:0] waddr, raddr;
  logic [1:0]    wdata, ram_q;
  logic [SW-1:0] half;
  logic          go_hi;
  int            k;

  assign half  = (lvl_r == '0) ? '0 : (SW'(1) << (lvl_r - LW'(1)));
  assign go_hi = {1'b0, addr_r} >= (base_r + half);
  assign k     = cnt_level(in_block_count);

  always_comb begin
    we    = 1'b0;
    waddr = n_r;
    wdata = ST_ABSENT;
    raddr = (cmd.op == OP_RDB) ? (n_r ^ NW'(1)) : n_r;
    unique case (cmd.op)
      OP_WR_HI:   begin we = 1'b1; waddr = {n_r[NW-2:0], 1'b1}; wdata = ST_FREE; end
      OP_SPLIT:   begin we = 1'b1; wdata = ST_SPLIT; end
      OP_WR_USED: begin we = 1'b1; wdata = ST_USED; end
      OP_WR_FREE: begin we = 1'b1; wdata = ST_FREE; end
      OP_WR_ABSN: begin we = 1'b1; wdata = ST_ABSENT; end
      OP_WR_ABSB: begin we = 1'b1; waddr = n_r ^ NW'(1); wdata = ST_ABSENT; end
      default: ;
    endcase
  end

  bal_ram #(.WIDTH(2), .DEPTH(TREE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (we) begin
      vld_r[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    vld_q_r   <= vld_r[raddr];
    raddr_q_r <= raddr;
  end

  always_comb begin
    stat.is_free_req = type_r;
    stat.cnt_bad     = (cnt_r == '0) || (32'(cnt_r) > 32'(MEM_UNITS));
    // a never-written node reads as its reset value: root free, rest absent
    stat.rd_st       = vld_q_r ? ram_q : ((raddr_q_r == NW'(1)) ? ST_FREE : ST_ABSENT);
    stat.at_root     = (n_r == NW'(1));
    stat.match       = (stat.rd_st == ST_USED) && (base_r == {1'b0, addr_r});
    stat.can_desc    = (stat.rd_st == ST_SPLIT) && (lvl_r != '0);
    stat.split_more  = (lvl_r > want_r);
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        type_r <= in_req_type;
        cnt_r  <= in_block_count;
        addr_r <= in_start_address;
        base_r <= '0;
        if (in_req_type) begin
          n_r   <= NW'(1);
          lvl_r <= LW'(LOG_UNITS);
        end else begin
          lvl_r   <= (k > LOG_UNITS) ? LW'(LOG_UNITS) : LW'(k);
          want_r  <= (k > LOG_UNITS) ? LW'(LOG_UNITS) : LW'(k);
          first_r <= NW'(MEM_UNITS >> ((k > LOG_UNITS) ? LOG_UNITS : k));
          n_r     <= NW'(MEM_UNITS >> ((k > LOG_UNITS) ? LOG_UNITS : k));
        end
      end
      OP_ASTEP: begin
        // advance along the level, then up to the next larger block size
        if (n_r == ((first_r << 1) - NW'(1))) begin
          first_r <= first_r >> 1;
          n_r     <= first_r >> 1;
          lvl_r   <= lvl_r + LW'(1);
        end else begin
          n_r <= n_r + NW'(1);
        end
      end
      OP_AFOUND: begin
        res_status_r  <= RES_OK;
        res_address_r <= AW'((n_r - first_r) << lvl_r);
        res_size_r    <= SW'(1) << want_r;
      end
      OP_SPLIT: begin
        n_r   <= n_r << 1;
        lvl_r <= lvl_r - LW'(1);
      end
      OP_FDESC: begin
        n_r   <= {n_r[NW-2:0], go_hi};
        lvl_r <= lvl_r - LW'(1);
        if (go_hi) base_r <= base_r + half;
      end
      OP_FFOUND: begin
        res_status_r  <= RES_OK;
        res_address_r <= addr_r;
        res_size_r    <= SW'(1) << lvl_r;
      end
      OP_WR_ABSB: begin
        n_r   <= n_r >> 1;
        lvl_r <= lvl_r + LW'(1);
      end
      OP_ERR: begin
        res_status_r  <= cmd.err;
        res_address_r <= '0;
        res_size_r    <= '0;
      end
      default: ;
    endcase
  end

  assign res_status  = res_status_r;
  assign res_address = res_address_r;
  assign res_size    = res_size_r;

endmodule

### hdl/bal_ctrl.sv
// ----------------------------------------------------------------------------
// Buddy allocator controller
// Sequences the tree search, split and merge steps and the handshakes.
// ----------------------------------------------------------------------------
module bal_ctrl import bal_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_A_RD  = 4'd2;
  localparam logic [3:0] S_A_CHK = 4'd3;
  localparam logic [3:0] S_A_SPL = 4'd4;
  localparam logic [3:0] S_A_SP2 = 4'd5;
  localparam logic [3:0] S_F_RD  = 4'd6;
  localparam logic [3:0] S_F_CHK = 4'd7;
  localparam logic [3:0] S_F_BRD = 4'd8;
  localparam logic [3:0] S_F_BCK = 4'd9;
  localparam logic [3:0] S_F_ABB = 4'd10;
  localparam logic [3:0] S_RESP  = 4'd11;

  logic [3:0] state_r, state_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_RESP);

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    cmd.err   = RES_OK;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        priority if (stat.is_free_req) begin
          state_nxt = S_F_RD;
        end else if (stat.cnt_bad) begin
          cmd.op = OP_ERR; cmd.err = RES_BAD_CNT; state_nxt = S_RESP;
        end else begin
          state_nxt = S_A_RD;
        end
      end
      S_A_RD: begin cmd.op = OP_RD; state_nxt = S_A_CHK; end
      S_A_CHK: begin
        priority if (stat.rd_st == ST_FREE) begin
          cmd.op = OP_AFOUND; state_nxt = S_A_SPL;
        end else if (stat.at_root) begin
          cmd.op = OP_ERR; cmd.err = RES_NO_SPC; state_nxt = S_RESP;
        end else begin
          cmd.op = OP_ASTEP; state_nxt = S_A_RD;
        end
      end
      S_A_SPL: begin
        if (stat.split_more) begin
          cmd.op = OP_WR_HI; state_nxt = S_A_SP2;
        end else begin
          cmd.op = OP_WR_USED; state_nxt = S_RESP;
        end
      end
      S_A_SP2: begin cmd.op = OP_SPLIT; state_nxt = S_A_SPL; end
      S_F_RD:  begin cmd.op = OP_RD; state_nxt = S_F_CHK; end
      S_F_CHK: begin
        priority if (stat.match) begin
          cmd.op = OP_FFOUND; state_nxt = S_F_BRD;
        end else if (stat.can_desc) begin
          cmd.op = OP_FDESC; state_nxt = S_F_RD;
        end else begin
          cmd.op = OP_ERR; cmd.err = RES_NO_BLK; state_nxt = S_RESP;
        end
      end
      S_F_BRD: begin
        if (stat.at_root) begin
          cmd.op = OP_WR_FREE; state_nxt = S_RESP;
        end else begin
          cmd.op = OP_RDB; state_nxt = S_F_BCK;
        end
      end
      S_F_BCK: begin
        // merge while the buddy is free and unsplit
        if (stat.rd_st == ST_FREE) begin
          cmd.op = OP_WR_ABSN; state_nxt = S_F_ABB;
        end else begin
          cmd.op = OP_WR_FREE; state_nxt = S_RESP;
        end
      end
      S_F_ABB: begin cmd.op = OP_WR_ABSB; state_nxt = S_F_BRD; end
      S_RESP: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

`ifndef SYNTHESIS
  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_DISP)
    else $error("accepted request not dispatched");
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input taken while result pending");
  a_resp_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=> in_ready)
    else $error("not idle after result beat");
`endif

endmodule

### hdl/buddy_allocator_core.sv
// ----------------------------------------------------------------------------
// Buddy allocator core
// Binary buddy allocator over a 64-unit pool kept as a tree of block states.
// ----------------------------------------------------------------------------
// Input channel in_*: one beat per request. in_req_type 0 allocates
// in_block_count units (rounded up to a power of two), 1 frees the used block
// starting at in_start_address. Output channel out_*: one result beat per
// request with status, block address and granted size.
// One request is in flight at a time. Latency is set by the walk over the
// node state memory (one write port, one read port with registered data):
//   allocate: scan each level from the wanted size upward for a free node,
//             then split it down to the wanted size;
//   free:     descend from the root to the used block, then merge free buddies.
// A bad count is answered from the dispatch state, without a tree walk.
// Reset empties the pool at once (root free); no clearing pass is needed.
// While the receiver stalls the result beat holds and no request is taken.
// ----------------------------------------------------------------------------
module buddy_allocator_core import bal_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          in_req_type,
  input  logic [CW-1:0] in_block_count,
  input  logic [AW-1:0] in_start_address,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [1:0]    out_status,
  output logic [AW-1:0] out_block_address,
  output logic [SW-1:0] out_granted_size
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  bal_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bal_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_req_type      (in_req_type),
    .in_block_count   (in_block_count),
    .in_start_address (in_start_address),
    .stat             (stat),
    .res_status       (out_status),
    .res_address      (out_block_address),
    .res_size         (out_granted_size)
  );

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// Buddy allocator core testbench
// Drives allocate and free requests and checks every result beat against an
// in-bench model of the block tree. Both channels idle at random, except in the last random run.
// ----------------------------------------------------------------------------
module testbench;
  import bal_pkg::*;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  logic          in_req_type = 1'b0;
  logic [CW-1:0] in_block_count = '0;
  logic [AW-1:0] in_start_address = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  logic [1:0]    out_status;
  logic [AW-1:0] out_block_address;
  logic [SW-1:0] out_granted_size;

  typedef struct packed {
    logic [1:0]    status;
    logic [AW-1:0] addr;
    logic [SW-1:0] size;
  } alloc_res_t;

  logic [1:0]  tree_st [1:TREE_DEPTH-1];
  alloc_res_t  pending_q [$];
  int          fail_cnt = 0;
  int          beat_cnt = 0;
  int          ok_cnt = 0;
  int          nospace_cnt = 0;
  int          noblk_cnt = 0;
  bit          idle_on = 1'b1;
  int          live_addr [$];

  buddy_allocator_core DUT (.*);

  always #5 clk = ~clk;

  function automatic alloc_res_t model_alloc(input logic [CW-1:0] cnt);
    alloc_res_t r;
    int want, sz, first, n, cur;
    r = '0;
    if (cnt == 0 || cnt > MEM_UNITS) begin
      r.status = RES_BAD_CNT;
      return r;
    end
    want = 1;
    while (want < cnt) want = want * 2;
    for (sz = want; sz <= MEM_UNITS; sz = sz * 2) begin
      first = MEM_UNITS / sz;
      for (int i = 0; i < first; i++) begin
        n = first + i;
        if (tree_st[n] == ST_FREE) begin
          cur = sz;
          while (cur > want) begin
            tree_st[n] = ST_SPLIT;
            tree_st[2*n] = ST_FREE;
            tree_st[2*n+1] = ST_FREE;
            n = 2 * n;
            cur = cur / 2;
          end
          tree_st[n] = ST_USED;
          r.status = RES_OK;
          r.addr = AW'(i * sz);
          r.size = SW'(want);
          return r;
        end
      end
    end
    r.status = RES_NO_SPC;
    return r;
  endfunction

  function automatic alloc_res_t model_free(input logic [AW-1:0] a);
    alloc_res_t r;
    int n, sz, base, half;
    r = '0;
    n = 1; sz = MEM_UNITS; base = 0;
    forever begin
      if (tree_st[n] == ST_USED && base == a) break;
      if (tree_st[n] == ST_SPLIT && sz > 1) begin
        half = sz / 2;
        if (a >= base + half) begin
          n = 2 * n + 1;
          base = base + half;
        end else begin
          n = 2 * n;
        end
        sz = half;
      end else begin
        r.status = RES_NO_BLK;
        return r;
      end
    end
    tree_st[n] = ST_FREE;
    while (n > 1) begin
      if (tree_st[n ^ 1] != ST_FREE) break;
      tree_st[n] = ST_ABSENT;
      tree_st[n ^ 1] = ST_ABSENT;
      n = n / 2;
      tree_st[n] = ST_FREE;
    end
    r.status = RES_OK;
    r.addr = a;
    r.size = SW'(sz);
    return r;
  endfunction

  task automatic idle_burst();
    if (idle_on && $urandom_range(0, 3) == 0) begin
      // drop valid for the idle cycles
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
  endtask

  // Send one request beat and predict its result.
  task automatic send_req(input logic op, input logic [CW-1:0] cnt,
                          input logic [AW-1:0] a);
    alloc_res_t r;
    idle_burst();
    in_valid <= 1'b1;
    in_req_type <= op;
    in_block_count <= cnt;
    in_start_address <= a;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = op ? model_free(a) : model_alloc(cnt);
    if (r.status == RES_OK) begin
      if (op == 1'b0) live_addr.push_back(int'(r.addr));
      else foreach (live_addr[i]) if (live_addr[i] == a) begin
        live_addr.delete(i);
        break;
      end
    end
    pending_q.push_back(r);
    // hold valid; the next request or drain decides its value
    @(negedge clk);
  endtask

  task automatic free_any();
    int k;
    if (live_addr.size() == 0) send_req(1'b1, 7'($urandom), 6'($urandom));
    else begin
      k = $urandom_range(0, live_addr.size() - 1);
      send_req(1'b1, 7'($urandom), AW'(live_addr[k]));
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_q.size() != 0);
  endtask

  always @(negedge clk) begin
    if (idle_on && $urandom_range(0, 3) == 0) out_ready <= 1'b0;
    else out_ready <= 1'b1;
  end

  always @(posedge clk) begin
    alloc_res_t e;
    if (rst_n && out_valid && out_ready) begin
      beat_cnt++;
      if (pending_q.size() == 0) begin
        $error("result beat with nothing pending");
        fail_cnt++;
      end else begin
        e = pending_q.pop_front();
        case (out_status)
          RES_OK:     ok_cnt++;
          RES_NO_SPC: nospace_cnt++;
          RES_NO_BLK: noblk_cnt++;
          default: ;
        endcase
        if (out_status !== e.status) begin
          $error("status: expected %0d actual %0d", e.status, out_status);
          fail_cnt++;
        end
        if (out_block_address !== e.addr) begin
          $error("block_address: expected %0d actual %0d", e.addr, out_block_address);
          fail_cnt++;
        end
        if (out_granted_size !== e.size) begin
          $error("granted_size: expected %0d actual %0d", e.size, out_granted_size);
          fail_cnt++;
        end
      end
    end
  end

  task automatic test_directed();
    send_req(1'b0, 7'd0, 6'd63);
    send_req(1'b0, 7'd65, 6'd0);
    send_req(1'b0, 7'd127, 6'd0);
    send_req(1'b1, 7'd0, 6'd0);
    send_req(1'b0, 7'd64, 6'd0);
    send_req(1'b0, 7'd1, 6'd0);
    send_req(1'b1, 7'd127, 6'd1);
    send_req(1'b1, 7'd0, 6'd0);
    send_req(1'b0, 7'd1, 6'd0);
    send_req(1'b0, 7'd3, 6'd0);
    send_req(1'b0, 7'd33, 6'd0);
    send_req(1'b0, 7'd16, 6'd0);
    send_req(1'b1, 7'd0, 6'd4);
    send_req(1'b1, 7'd0, 6'd5);
    send_req(1'b1, 7'd0, 6'd0);
    send_req(1'b1, 7'd0, 6'd0);
    send_req(1'b1, 7'd0, 6'd16);
    send_req(1'b1, 7'd0, 6'd32);
    send_req(1'b0, 7'd42, 6'd42);
    send_req(1'b1, 7'd85, 6'd63);
    send_req(1'b1, 7'd0, 6'd0);
    drain();
  endtask

  task automatic test_random(input int n_items);
    int c;
    for (int i = 0; i < n_items; i++) begin
      c = $urandom_range(0, 9);
      if (c < 5) begin
        // mostly small sizes so the tree fragments
        if ($urandom_range(0, 9) == 0) send_req(1'b0, 7'($urandom), 6'($urandom));
        else send_req(1'b0, 7'($urandom_range(1, 1 << $urandom_range(0, 5))),
                      6'($urandom));
      end else if (c < 9) begin
        free_any();
      end else begin
        send_req(1'b1, 7'($urandom), 6'($urandom));
      end
    end
    drain();
  endtask

  initial begin
    for (int i = 1; i < TREE_DEPTH; i++) tree_st[i] = ST_ABSENT;
    tree_st[1] = ST_FREE;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random(1200);
    while (live_addr.size() != 0) free_any();
    drain();
    idle_on = 1'b0;
    test_random(500);
    repeat (300) @(negedge clk);
    $display("Checked %0d result beats: %0d ok, %0d no space, %0d no block.",
             beat_cnt, ok_cnt, nospace_cnt, noblk_cnt);
    if (fail_cnt == 0 && pending_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

### sim.f
hdl/bal_pkg.sv
hdl/bal_ram.sv
hdl/bal_datapath.sv
hdl/bal_ctrl.sv
hdl/buddy_allocator_core.sv
tb/testbench.sv
